[design/vpts_pkg.sv]
// Shared types, constants and helper functions of the vertex projection pipeline.
// Used by every module of the block; it depends on nothing else.
package vpts_pkg;

  // Fixed-point format of coefficients, positions and splat size.
  localparam int FRAC_BITS = 12;

  // Datapath widths.
  localparam int COEF_W  = 16;
  localparam int PROD_W  = 32;
  localparam int CLIP_W  = 34;
  localparam int NUM_W   = 53;
  localparam int DEN_W   = 36;
  localparam int QUO_W   = 20;
  localparam int REM_W   = 56;
  localparam int VP_W    = 13;
  localparam int LANES   = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Pipeline depth from an accepted start to the result strobe.
  localparam int XFORM_STAGES = 2;
  localparam int PREP_STAGES  = 2;
  localparam int LATENCY      = XFORM_STAGES + PREP_STAGES + QUO_W + 1;

  // Quotient lanes.
  localparam int LANE_SX = 0;
  localparam int LANE_SY = 1;
  localparam int LANE_DZ = 2;
  localparam int LANE_SW = 3;
  localparam int LANE_SH = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VPW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VPH  = 3'd5;

  // Register reset values: identity matrix and an 800 by 600 viewport.
  localparam logic [CFG_DATA_W-1:0] ROW0_RST = 64'h0000_0000_0000_1000;
  localparam logic [CFG_DATA_W-1:0] ROW1_RST = 64'h0000_0000_1000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW2_RST = 64'h0000_1000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] ROW3_RST = 64'h1000_0000_0000_0000;
  localparam logic [VP_W-1:0] VPW_RST = 13'd800;
  localparam logic [VP_W-1:0] VPH_RST = 13'd600;

  // Saturation limits of the screen coordinates.
  localparam logic signed [19:0] SCR_MIN = 20'sh80000;
  localparam logic signed [19:0] SCR_MAX = 20'sh7FFFF;

  typedef logic [3:0][CFG_DATA_W-1:0] matrix_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        splat_size;
    logic [23:0]        color;
  } in_item_t;

  typedef struct packed {
    logic               visible;
    logic signed [19:0] screen_x;
    logic signed [19:0] screen_y;
    logic [15:0]        depth;
    logic [15:0]        splat_width;
    logic [15:0]        splat_height;
    logic [23:0]        color_out;
  } out_item_t;

  typedef struct packed {
    logic signed [CLIP_W-1:0] x;
    logic signed [CLIP_W-1:0] y;
    logic signed [CLIP_W-1:0] z;
    logic signed [CLIP_W-1:0] w;
  } clip_t;

  // Per-item data that rides alongside the arithmetic.
  typedef struct packed {
    logic        visible;
    logic [15:0] size;
    logic [23:0] color;
  } side_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] q;
    logic             neg;
    logic             ovf;
  } div_lane_t;

  typedef div_lane_t [LANES-1:0] lane_vec_t;

  // Turns a rounded signed quotient n / d into an unsigned floor division.
  // A negative numerator is folded so that the quotient magnitude is a ceiling;
  // a zero divisor saturates toward the sign of the numerator.
  function automatic div_lane_t prep_lane(input logic signed [NUM_W-1:0] n,
                                          input logic signed [CLIP_W:0] d);
    logic signed [NUM_W:0]    nn;
    logic signed [CLIP_W+1:0] dd;
    logic signed [NUM_W+1:0]  num;
    logic [NUM_W+1:0]         mag;
    logic [DEN_W-1:0]         den;
    logic [REM_W-1:0]         m;
    div_lane_t                l;
    l = '0;
    if (d == 0) begin
      l.rem = '0;
      l.den = DEN_W'(1);
      l.neg = n < 0;
      l.ovf = n != 0;
    end else begin
      nn = {n[NUM_W-1], n};
      dd = {d[CLIP_W], d};
      if (d < 0) begin
        nn = -nn;
        dd = -dd;
      end
      num = {nn, 1'b0} + {{(NUM_W-CLIP_W){dd[CLIP_W+1]}}, dd};
      den = {dd[DEN_W-2:0], 1'b0};
      l.neg = num[NUM_W+1];
      if (l.neg) begin
        mag = -num;
        m = REM_W'(mag) + REM_W'(den) - REM_W'(1);
      end else begin
        mag = num;
        m = REM_W'(mag);
      end
      l.rem = m;
      l.den = den;
      l.ovf = m >= (REM_W'(den) << QUO_W);
    end
    return l;
  endfunction

  // Saturates a lane result to the signed screen range.
  function automatic logic signed [19:0] sat_screen(input div_lane_t l);
    logic signed [19:0] r;
    if (l.neg) begin
      if (l.ovf || l.q > QUO_W'(20'h80000)) r = SCR_MIN;
      else r = -$signed(l.q);
    end else begin
      if (l.ovf || l.q > QUO_W'(20'h7FFFF)) r = SCR_MAX;
      else r = $signed(l.q);
    end
    return r;
  endfunction

  // Saturates a lane result to 0..65535.
  function automatic logic [15:0] sat_u16(input div_lane_t l);
    logic [15:0] r;
    if (l.neg) r = '0;
    else if (l.ovf || l.q > QUO_W'(20'h0FFFF)) r = 16'hFFFF;
    else r = l.q[15:0];
    return r;
  endfunction

endpackage

[design/vpts_xform.sv]
// Matrix stage of the vertex projection: sixteen products, then four row sums.
// Depends on vpts_pkg.
module vpts_xform (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  vpts_pkg::in_item_t in_item,
  input  vpts_pkg::matrix_t  matrix,
  output logic               clip_valid,
  output vpts_pkg::clip_t    clip,
  output vpts_pkg::side_t    side
);
  import vpts_pkg::*;

  logic signed [PROD_W-1:0] prod_r [4][4];
  logic signed [PROD_W-1:0] prod_nxt [4][4];
  logic signed [15:0]       pos [3];
  logic                     valid1_r, valid2_r;
  side_t                    side1_r, side2_r, side2_nxt;
  clip_t                    clip_r, clip_nxt;
  logic signed [CLIP_W-1:0] sum [4];

  // First stage: every coefficient times its position term.
  always_comb begin
    pos[0] = in_item.pos_x;
    pos[1] = in_item.pos_y;
    pos[2] = in_item.pos_z;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = $signed(matrix[r][COEF_W*c +: COEF_W]) * pos[c];
      end
      prod_nxt[r][3] = PROD_W'($signed(matrix[r][COEF_W*3 +: COEF_W])) <<< FRAC_BITS;
    end
  end

  // Second stage: row sums give the clip coordinates.
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum[r] = CLIP_W'(prod_r[r][0]) + CLIP_W'(prod_r[r][1])
             + CLIP_W'(prod_r[r][2]) + CLIP_W'(prod_r[r][3]);
    end
    clip_nxt.x = sum[0];
    clip_nxt.y = sum[1];
    clip_nxt.z = sum[2];
    clip_nxt.w = sum[3];
    side2_nxt = side1_r;
    side2_nxt.visible = sum[2] > 0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    side1_r.visible <= 1'b0;
    side1_r.size <= in_item.splat_size;
    side1_r.color <= in_item.color;
    clip_r <= clip_nxt;
    side2_r <= side2_nxt;
  end

  assign clip_valid = valid2_r;
  assign clip = clip_r;
  assign side = side2_r;

endmodule

[design/vpts_prep.sv]
// Numerator and divisor preparation for the five quotients of the projection.
// Depends on vpts_pkg.
module vpts_prep (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clip_valid,
  input  vpts_pkg::clip_t            clip,
  input  vpts_pkg::side_t            side,
  input  logic [vpts_pkg::VP_W-1:0]  vp_width,
  input  logic [vpts_pkg::VP_W-1:0]  vp_height,
  output logic                       lane_valid,
  output vpts_pkg::lane_vec_t        lanes,
  output vpts_pkg::side_t            lane_side
);
  import vpts_pkg::*;

  logic signed [NUM_W-1:0]  n_r [LANES];
  logic signed [NUM_W-1:0]  n_nxt [LANES];
  logic signed [CLIP_W-1:0] w_r;
  logic signed [CLIP_W:0]   xw, wy, d_half, d_full;
  logic signed [VP_W:0]     vw_s, vh_s;
  logic signed [16:0]       size_s;
  logic                     valid3_r, valid4_r;
  side_t                    side3_r, side4_r;
  lane_vec_t                lanes_r, lanes_nxt;

  // Third stage: the five numerators.
  always_comb begin
    vw_s = $signed({1'b0, vp_width});
    vh_s = $signed({1'b0, vp_height});
    size_s = $signed({1'b0, side.size});
    xw = (CLIP_W+1)'(clip.x) + (CLIP_W+1)'(clip.w);
    wy = (CLIP_W+1)'(clip.w) - (CLIP_W+1)'(clip.y);
    n_nxt[LANE_SX] = (vw_s * xw) <<< 4;
    n_nxt[LANE_SY] = (vh_s * wy) <<< 4;
    n_nxt[LANE_DZ] = NUM_W'(clip.z) <<< 16;
    n_nxt[LANE_SW] = (vw_s * size_s) <<< (4 + FRAC_BITS);
    n_nxt[LANE_SH] = (vh_s * size_s) <<< (4 + FRAC_BITS);
  end

  // Fourth stage: sign folding, rounding offset and the overflow check.
  always_comb begin
    d_full = {w_r, 1'b0};
    d_half = (CLIP_W+1)'(w_r);
    lanes_nxt[LANE_SX] = prep_lane(n_r[LANE_SX], d_full);
    lanes_nxt[LANE_SY] = prep_lane(n_r[LANE_SY], d_full);
    lanes_nxt[LANE_DZ] = prep_lane(n_r[LANE_DZ], d_half);
    lanes_nxt[LANE_SW] = prep_lane(n_r[LANE_SW], d_half);
    lanes_nxt[LANE_SH] = prep_lane(n_r[LANE_SH], d_half);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid3_r <= 1'b0;
      valid4_r <= 1'b0;
    end else begin
      valid3_r <= clip_valid;
      valid4_r <= valid3_r;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    w_r <= clip.w;
    side3_r <= side;
    lanes_r <= lanes_nxt;
    side4_r <= side3_r;
  end

  assign lane_valid = valid4_r;
  assign lanes = lanes_r;
  assign lane_side = side4_r;

endmodule

[design/vpts_div.sv]
// Pipelined restoring divider: one quotient bit per stage for five lanes at once.
// Depends on vpts_pkg.
module vpts_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 lane_valid,
  input  vpts_pkg::lane_vec_t  lanes,
  input  vpts_pkg::side_t      lane_side,
  output logic                 quo_valid,
  output vpts_pkg::lane_vec_t  quo_lanes,
  output vpts_pkg::side_t      quo_side
);
  import vpts_pkg::*;

  lane_vec_t          stage_r [QUO_W];
  lane_vec_t          stage_nxt [QUO_W];
  side_t              side_r [QUO_W];
  logic [QUO_W-1:0]   valid_r;

  // Each stage tries the divisor shifted to its own quotient bit.
  always_comb begin
    lane_vec_t        src;
    logic [REM_W-1:0] trial;
    for (int s = 0; s < QUO_W; s++) begin
      src = (s == 0) ? lanes : stage_r[s-1];
      stage_nxt[s] = src;
      for (int k = 0; k < LANES; k++) begin
        trial = REM_W'(src[k].den) << (QUO_W - 1 - s);
        if (src[k].rem >= trial) begin
          stage_nxt[s][k].rem = src[k].rem - trial;
          stage_nxt[s][k].q[QUO_W-1-s] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[QUO_W-2:0], lane_valid};
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    side_r[0] <= lane_side;
    for (int s = 1; s < QUO_W; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  assign quo_valid = valid_r[QUO_W-1];
  assign quo_lanes = stage_r[QUO_W-1];
  assign quo_side = side_r[QUO_W-1];

endmodule

[design/vertex_project_to_screen_top.sv]
// Top level of the vertex projection pipeline: configuration registers and output stage.
// Depends on vpts_pkg, vpts_xform, vpts_prep and vpts_div.
//
// Usage: drive a vertex on in_item and raise start for one cycle per item. The block
// never holds off input, so busy stays low and an item may be presented in every cycle.
// Each item gives exactly one result: out_strobe is high for one cycle with the result
// on out_item, once the item has passed through every pipeline register. The
// sustained rate is one item per cycle. The pipeline is two matrix stages, two numerator
// stages, the restoring divider, which resolves one quotient bit per stage over twenty
// stages, and the registered output stage.
// The receiver takes each result in the cycle that it is shown and cannot stall.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); rows 0 to 3 hold
// the matrix, indexes 4 and 5 the viewport size, and other indexes are ignored.
// Registers should only be written while no item is in flight.
// Synchronous reset loads the identity matrix and an 800 by 600 viewport and empties
// the pipeline; items in flight at reset are dropped.
module vertex_project_to_screen_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  vpts_pkg::in_item_t                  in_item,
  output logic                                out_strobe,
  output vpts_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [vpts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vpts_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import vpts_pkg::*;

  matrix_t        matrix_r;
  logic [VP_W-1:0] vpw_r, vph_r;
  logic           clip_valid, lane_valid, quo_valid;
  clip_t          clip;
  side_t          side, lane_side, quo_side;
  lane_vec_t      lanes, quo_lanes;
  logic           out_strobe_r;
  out_item_t      out_item_r, out_item_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r[0] <= ROW0_RST;
      matrix_r[1] <= ROW1_RST;
      matrix_r[2] <= ROW2_RST;
      matrix_r[3] <= ROW3_RST;
      vpw_r <= VPW_RST;
      vph_r <= VPH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW0: matrix_r[0] <= cfg_wdata;
        CFG_ROW1: matrix_r[1] <= cfg_wdata;
        CFG_ROW2: matrix_r[2] <= cfg_wdata;
        CFG_ROW3: matrix_r[3] <= cfg_wdata;
        CFG_VPW:  vpw_r <= cfg_wdata[VP_W-1:0];
        CFG_VPH:  vph_r <= cfg_wdata[VP_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  vpts_xform u_xform (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && !busy),
    .in_item    (in_item),
    .matrix     (matrix_r),
    .clip_valid (clip_valid),
    .clip       (clip),
    .side       (side)
  );

  vpts_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .clip_valid (clip_valid),
    .clip       (clip),
    .side       (side),
    .vp_width   (vpw_r),
    .vp_height  (vph_r),
    .lane_valid (lane_valid),
    .lanes      (lanes),
    .lane_side  (lane_side)
  );

  vpts_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .lane_valid (lane_valid),
    .lanes      (lanes),
    .lane_side  (lane_side),
    .quo_valid  (quo_valid),
    .quo_lanes  (quo_lanes),
    .quo_side   (quo_side)
  );

  // Output stage: saturation, and all fields cleared for an invisible point.
  always_comb begin
    out_item_nxt = '0;
    if (quo_side.visible) begin
      out_item_nxt.visible      = 1'b1;
      out_item_nxt.screen_x     = sat_screen(quo_lanes[LANE_SX]);
      out_item_nxt.screen_y     = sat_screen(quo_lanes[LANE_SY]);
      out_item_nxt.depth        = sat_u16(quo_lanes[LANE_DZ]);
      out_item_nxt.splat_width  = sat_u16(quo_lanes[LANE_SW]);
      out_item_nxt.splat_height = sat_u16(quo_lanes[LANE_SH]);
      out_item_nxt.color_out    = quo_side.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item = out_item_r;

  // Every transfer in gives a result after the fixed latency.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("accepted item gave no result");

  // No result appears without an item taken the fixed latency earlier.
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  // An invisible point carries only zero fields.
  a_invisible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.visible) |-> (out_item.screen_x == 0 &&
      out_item.screen_y == 0 && out_item.depth == 0 && out_item.splat_width == 0 &&
      out_item.splat_height == 0 && out_item.color_out == 0))
    else $error("invisible result with non-zero fields");

endmodule
